/* rtl/sks_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the sorted-store block
// no dependencies; used by every module of the block by scoped names
package sks_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 30;

    localparam int OPW     = 31;                          // operand width
    localparam int SUM_W   = 40;                          // result sum width
    localparam int HC_W    = 11;                          // held_count port width
    localparam int CNT_W   = $clog2(CAPACITY + 1);        // internal count width

    // readout tree: groups of 32 prefix sums, power-of-two group count
    localparam int LO_W    = 5;
    localparam int GROUP   = 1 << LO_W;
    localparam int NGROUP0 = (CAPACITY + GROUP - 1) / GROUP;
    localparam int HI_W    = (NGROUP0 > 1) ? $clog2(NGROUP0) : 1;
    localparam int NGROUP  = 1 << HI_W;
    localparam int SEL_W   = HI_W + LO_W;
    localparam int PAD     = NGROUP * GROUP;

    localparam int XW      = ((OPW > VALUE_BITS) ? OPW : VALUE_BITS) + 1;
    localparam int SW_EXT  = ((SUM_W > VALUE_BITS) ? SUM_W : VALUE_BITS) + 1;
    localparam int KW      = ((OPW > CNT_W) ? OPW : CNT_W) + 1;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [SUM_W-1:0]      SUM_MAX   = '1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [CNT_W-1:0]      count_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic   ins_en;
        value_t ins_val;
        count_t count;
    } ctl_t;

    // clamp a nonnegative operand to the value range
    function automatic value_t sat_value(input logic [OPW-1:0] x);
        logic [XW-1:0] xe;
        xe = XW'(x);
        if (xe > XW'(VALUE_MAX))
            return VALUE_MAX;
        return VALUE_BITS'(xe);
    endfunction

    // saturating prefix-sum add
    function automatic sum_t sat_add(input sum_t p, input value_t v);
        logic [SW_EXT-1:0] a;
        a = SW_EXT'(p) + SW_EXT'(v);
        if (a > SW_EXT'(SUM_MAX))
            return SUM_MAX;
        return SUM_W'(a);
    endfunction

endpackage

/* rtl/sks_cell.sv */
`timescale 1ns / 1ps
// one position of the sorted chain: a value and the running prefix sum up to it
// depends on sks_pkg
module sks_cell (
    input  logic             clk,
    input  sks_pkg::count_t  cell_idx,
    input  sks_pkg::ctl_t    ctl,
    input  logic             prev_gt,
    input  sks_pkg::value_t  prev_value,
    input  sks_pkg::sum_t    prev_prefix,
    output logic             gt,
    output sks_pkg::value_t  value,
    output sks_pkg::sum_t    prefix
);

    sks_pkg::value_t value_reg;
    sks_pkg::value_t value_next;
    sks_pkg::sum_t   prefix_reg;
    sks_pkg::sum_t   prefix_next;
    logic            occupied;
    logic            at_end;

    assign occupied = cell_idx < ctl.count;
    assign at_end   = cell_idx == ctl.count;
    assign gt       = occupied && (value_reg > ctl.ins_val);

    always_comb
    begin
        value_next  = value_reg;
        prefix_next = prefix_reg;
        if (ctl.ins_en)
        begin
            // shift up behind a larger neighbor, or take the new value here
            if (prev_gt)
            begin
                value_next  = prev_value;
                prefix_next = sks_pkg::sat_add(prev_prefix, ctl.ins_val);
            end
            else if (gt || at_end)
            begin
                value_next  = ctl.ins_val;
                prefix_next = sks_pkg::sat_add(prev_prefix, ctl.ins_val);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        prefix_reg <= prefix_next;
    end

    assign value  = value_reg;
    assign prefix = prefix_reg;

endmodule

/* rtl/sks_chain.sv */
`timescale 1ns / 1ps
// row of sorted cells with neighbor links; exposes every prefix sum
// depends on sks_pkg and sks_cell
module sks_chain (
    input  logic                                      clk,
    input  sks_pkg::ctl_t                             ctl,
    output sks_pkg::sum_t [sks_pkg::CAPACITY-1:0]     prefix
);

    logic            gt_w     [sks_pkg::CAPACITY];
    sks_pkg::value_t value_w  [sks_pkg::CAPACITY];

    for (genvar i = 0; i < sks_pkg::CAPACITY; i++)
    begin : g_cell
        logic            p_gt;
        sks_pkg::value_t p_value;
        sks_pkg::sum_t   p_prefix;

        if (i == 0)
        begin : g_head
            assign p_gt     = 1'b0;
            assign p_value  = '0;
            assign p_prefix = '0;
        end
        else
        begin : g_link
            assign p_gt     = gt_w[i-1];
            assign p_value  = value_w[i-1];
            assign p_prefix = prefix[i-1];
        end

        sks_cell u_cell (
            .clk         (clk),
            .cell_idx    (sks_pkg::CNT_W'(i)),
            .ctl         (ctl),
            .prev_gt     (p_gt),
            .prev_value  (p_value),
            .prev_prefix (p_prefix),
            .gt          (gt_w[i]),
            .value       (value_w[i]),
            .prefix      (prefix[i])
        );
    end

endmodule

/* rtl/sks_readout.sv */
`timescale 1ns / 1ps
// two-level prefix-sum select: registered pick within each group, then group mux
// depends on sks_pkg
module sks_readout (
    input  logic                                      clk,
    input  logic                                      grp_en,
    input  sks_pkg::sum_t [sks_pkg::CAPACITY-1:0]     prefix,
    input  logic [sks_pkg::SEL_W-1:0]                 sel,
    output sks_pkg::sum_t                             sum
);

    sks_pkg::sum_t [sks_pkg::PAD-1:0] padded;
    sks_pkg::sum_t                    grp_reg [sks_pkg::NGROUP];

    for (genvar j = 0; j < sks_pkg::PAD; j++)
    begin : g_pad
        if (j < sks_pkg::CAPACITY)
        begin : g_used
            assign padded[j] = prefix[j];
        end
        else
        begin : g_zero
            assign padded[j] = '0;
        end
    end

    for (genvar g = 0; g < sks_pkg::NGROUP; g++)
    begin : g_grp
        localparam logic [sks_pkg::HI_W-1:0] GI = sks_pkg::HI_W'(g);

        always_ff @(posedge clk)
        begin
            if (grp_en)
                grp_reg[g] <= padded[{GI, sel[sks_pkg::LO_W-1:0]}];
        end
    end

    assign sum = grp_reg[sel[sks_pkg::SEL_W-1:sks_pkg::LO_W]];

endmodule

/* rtl/sum_of_k_smallest_store.sv */
`timescale 1ns / 1ps
// top level of the sorted multiset store with sum-of-k-smallest query
// depends on sks_pkg, sks_chain and sks_readout
//
// usage
//   a transaction is taken at a rising edge with start high and busy low;
//   opcode selects clear, insert operand, or query the sum of the operand
//   smallest values held
//   every transaction gives exactly one result: done is high for one cycle
//   with smallest_sum, held_count and overflow valid in that same cycle
//   the receiver cannot stall; a result is consumed the cycle it appears
// timing
//   accept edge, one execute cycle (the whole cell row shifts in parallel for
//   an insert, group prefix sums are latched for a query), one select cycle
//   (group mux), then done on the following cycle
//   busy is high only in the execute cycle, so a new transaction can be taken
//   while the previous one is in its select cycle; the pace is set by the
//   execute cycle, where the held count and the cells update
// reset
//   rst_n clears the sequencer, the held count and done; cell contents are
//   not cleared, they are ignored above the held count
// storage
//   each cell holds one sorted value and the saturating prefix sum of all
//   values up to it; an insert moves larger entries up one cell
module sum_of_k_smallest_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic signed [sks_pkg::OPW-1:0]     operand,
    output logic                               done,
    output logic [sks_pkg::SUM_W-1:0]          smallest_sum,
    output logic [sks_pkg::HC_W-1:0]           held_count,
    output logic                               overflow
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // transaction registers, loaded at accept
    logic [1:0]                 op_reg;
    sks_pkg::value_t            val_reg;
    logic                       ins_reg;
    logic                       ovf_reg;
    logic                       zero_reg;
    logic [sks_pkg::SEL_W-1:0]  sel_reg;

    sks_pkg::count_t            count_reg, count_next;

    // result registers
    logic                       done_reg;
    sks_pkg::sum_t              sum_reg;
    logic [sks_pkg::HC_W-1:0]   hc_reg;
    logic                       ovf_out_reg;

    logic                       accept;
    logic                       neg;
    logic                       full;
    logic [sks_pkg::KW-1:0]     k_ext;
    logic [sks_pkg::KW-1:0]     cnt_ext;
    sks_pkg::count_t            n_take;
    sks_pkg::count_t            n_m1;

    sks_pkg::ctl_t                            ctl;
    sks_pkg::sum_t [sks_pkg::CAPACITY-1:0]    prefix;
    sks_pkg::sum_t                            grp_sum;

    assign accept  = start && !busy;
    assign busy    = (state_reg == ST_EXEC);
    assign neg     = operand[sks_pkg::OPW-1];
    assign full    = (count_reg == sks_pkg::CNT_W'(sks_pkg::CAPACITY));

    // query length: min(k, count), index of its last element
    assign k_ext   = sks_pkg::KW'($unsigned(operand));
    assign cnt_ext = sks_pkg::KW'(count_reg);
    assign n_take  = (k_ext > cnt_ext) ? count_reg : sks_pkg::CNT_W'(k_ext);
    assign n_m1    = n_take - sks_pkg::CNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: state_next = accept ? ST_EXEC : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // decode of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            val_reg  <= sks_pkg::sat_value($unsigned(operand));
            zero_reg <= neg || (operand == '0) || (count_reg == '0);
            sel_reg  <= sks_pkg::SEL_W'(n_m1);
            case (opcode)
                sks_pkg::OP_INSERT:
                begin
                    ins_reg <= !neg && !full;
                    ovf_reg <= !neg && full;
                end
                default:
                begin
                    ins_reg <= 1'b0;
                    ovf_reg <= 1'b0;
                end
            endcase
        end
    end

    // held count changes in the execute cycle so the cells see the old count
    always_comb
    begin
        count_next = count_reg;
        if (state_reg == ST_EXEC)
        begin
            if (op_reg == sks_pkg::OP_CLEAR)
                count_next = '0;
            else if (ins_reg)
                count_next = count_reg + sks_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign ctl.ins_en  = (state_reg == ST_EXEC) && ins_reg;
    assign ctl.ins_val = val_reg;
    assign ctl.count   = count_reg;

    sks_chain u_chain (
        .clk    (clk),
        .ctl    (ctl),
        .prefix (prefix)
    );

    sks_readout u_readout (
        .clk    (clk),
        .grp_en (state_reg == ST_EXEC),
        .prefix (prefix),
        .sel    (sel_reg),
        .sum    (grp_sum)
    );

    // result stage, loaded at the end of the select cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == ST_DONE);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE)
        begin
            sum_reg     <= (op_reg == sks_pkg::OP_QUERY && !zero_reg) ? grp_sum : '0;
            hc_reg      <= sks_pkg::HC_W'(count_reg);
            ovf_out_reg <= ovf_reg;
        end
    end

    assign done         = done_reg;
    assign smallest_sum = sum_reg;
    assign held_count   = hc_reg;
    assign overflow     = ovf_out_reg;

    // checks
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted transaction did not enter execute");

    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_DONE && done == 1'b0)
        else $error("execute not followed by select");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(state_reg == ST_DONE))
        else $error("result strobe without a select cycle");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> count_reg == sks_pkg::CNT_W'(sks_pkg::CAPACITY))
        else $error("overflow reported while store not full");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_EXEC |=> $stable(count_reg))
        else $error("held count changed outside execute");

endmodule

/* dv/sum_of_k_smallest_store_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for sum_of_k_smallest_store: clear, insert and query transactions
// depends on sks_pkg and the rtl top level; a small scoreboard class tracks the sorted multiset
module sum_of_k_smallest_store_test;
    import sks_pkg::*;

    // opcode 3 is not decoded by the block, it only reports the count
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // sender keeps start high back to back inside this transaction window
    localparam int QUIET_FIRST = 300;
    localparam int QUIET_LAST  = 600;
    localparam int DRAIN_CYCLES = 8;

    typedef logic signed [OPW-1:0] operand_t;

    localparam operand_t OPERAND_MAX = {1'b0, {(OPW-1){1'b1}}};
    localparam operand_t OPERAND_MIN = {1'b1, {(OPW-1){1'b0}}};

    typedef struct packed {
        sum_t            sum;
        logic [HC_W-1:0] count;
        logic            ovf;
    } outcome_t;

    // shadow copy of the sorted multiset plus the queue of predicted outcomes
    class prefix_sum_tracker;
        value_t   shadow_vals[CAPACITY];
        int       shadow_count;
        outcome_t pending_outcomes[$];
        int       mismatches;

        function new();
            shadow_count = 0;
            mismatches   = 0;
        endfunction

        // predict the outcome of one accepted transaction
        function void note_command(input logic [1:0] op, input operand_t arg);
            longint   x;
            longint   acc;
            int       n;
            int       pos;
            value_t   v;
            outcome_t res;
            x   = arg;
            res = '0;
            case (op)
                OP_CLEAR:
                begin
                    shadow_count = 0;
                end
                OP_INSERT:
                begin
                    // negative values are ignored, a full store drops the value
                    if (x >= 0)
                    begin
                        if (shadow_count >= CAPACITY)
                            res.ovf = 1'b1;
                        else
                        begin
                            v = (x > longint'(VALUE_MAX)) ? VALUE_MAX : value_t'(x);
                            // equal values stay in front of the new one
                            pos = shadow_count;
                            while (pos > 0 && shadow_vals[pos-1] > v)
                            begin
                                shadow_vals[pos] = shadow_vals[pos-1];
                                pos--;
                            end
                            shadow_vals[pos] = v;
                            shadow_count++;
                        end
                    end
                end
                OP_QUERY:
                begin
                    if (x > 0)
                    begin
                        n   = (x > shadow_count) ? shadow_count : int'(x);
                        acc = 0;
                        for (int i = 0; i < n; i++)
                        begin
                            acc += shadow_vals[i];
                            if (acc > longint'(SUM_MAX))
                                acc = longint'(SUM_MAX);
                        end
                        res.sum = sum_t'(acc);
                    end
                end
                default:
                begin
                end
            endcase
            res.count = HC_W'(shadow_count);
            pending_outcomes.push_back(res);
        endfunction

        // compare one result against the oldest prediction
        function void check_result(input sum_t sum, input logic [HC_W-1:0] count,
                                   input logic ovf);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sum %0d count %0d overflow %0b",
                             sum, count, ovf);
                return;
            end
            want = pending_outcomes.pop_front();
            if (want.sum !== sum || want.count !== count || want.ovf !== ovf)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: sum %0d/%0d count %0d/%0d overflow %0b/%0b (exp/act)",
                             want.sum, sum, want.count, count, want.ovf, ovf);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           opcode = OP_CLEAR;
    operand_t             operand = '0;
    logic                 busy;
    logic                 done;
    logic [SUM_W-1:0]     smallest_sum;
    logic [HC_W-1:0]      held_count;
    logic                 overflow;

    prefix_sum_tracker tracker;
    int                items_sent = 0;

    sum_of_k_smallest_store uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .operand      (operand),
        .done         (done),
        .smallest_sum (smallest_sum),
        .held_count   (held_count),
        .overflow     (overflow)
    );

    always #6 clk = ~clk;

    // results cannot be stalled: every done cycle is a transaction result
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            tracker.check_result(smallest_sum, held_count, overflow);
    end

    // random gap after a transaction, none inside the quiet window
    task automatic idle_between();
        if (items_sent >= QUIET_FIRST && items_sent <= QUIET_LAST)
            return;
        if ($urandom_range(99) < 24)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // present one transaction and hold it until the block takes it
    task automatic issue(input logic [1:0] op, input operand_t arg);
        start   <= 1'b1;
        opcode  <= op;
        operand <= arg;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tracker.note_command(op, arg);
        items_sent++;
        idle_between();
    endtask

    // sender holds off until every predicted result has been seen
    task automatic wait_for_results();
        start <= 1'b0;
        while (tracker.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // insert operand: extremes, small duplicates, wide values, negatives
    function automatic operand_t pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return OPERAND_MAX;
            2, 3, 4: return operand_t'($urandom_range(15));
            5, 6, 7: return {1'b0, (OPW-1)'($urandom)};
            8:       return {1'b1, (OPW-1)'($urandom)};
            default: return operand_t'($urandom);
        endcase
    endfunction

    // query k: mostly around the held count, with zero, negative and huge k
    function automatic operand_t pick_k();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {1'b1, (OPW-1)'($urandom)};
            2:       return OPERAND_MAX;
            8:       return operand_t'(tracker.shadow_count);
            9:       return operand_t'($urandom);
            default: return operand_t'($urandom_range(tracker.shadow_count + 2));
        endcase
    endfunction

    initial
    begin
        int       r;
        operand_t v;

        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, duplicates, k edge cases
        issue(OP_QUERY, operand_t'(5));
        issue(OP_INSERT, '0);
        issue(OP_INSERT, OPERAND_MAX);
        issue(OP_INSERT, OPERAND_MIN);
        issue(OP_INSERT, '1);
        issue(OP_INSERT, operand_t'(7));
        issue(OP_INSERT, operand_t'(7));
        issue(OP_INSERT, operand_t'(3));
        issue(OP_QUERY, '0);
        issue(OP_QUERY, '1);
        issue(OP_QUERY, OPERAND_MIN);
        issue(OP_QUERY, operand_t'(1));
        issue(OP_QUERY, operand_t'(3));
        issue(OP_QUERY, operand_t'(5));
        issue(OP_QUERY, OPERAND_MAX);
        issue(OP_UNUSED, operand_t'($urandom));
        issue(OP_CLEAR, '1);
        issue(OP_QUERY, operand_t'(2));
        issue(OP_INSERT, operand_t'(5));
        issue(OP_QUERY, operand_t'(1));

        // random mix on a small store
        for (int i = 0; i < 100; i++)
        begin
            r = $urandom_range(99);
            if (r < 4)
                issue(OP_CLEAR, operand_t'($urandom));
            else if (r < 8)
                issue(OP_UNUSED, operand_t'($urandom));
            else if (r < 58)
                issue(OP_INSERT, pick_value());
            else
                issue(OP_QUERY, pick_k());
        end

        wait_for_results();

        // fill the store to capacity with queries sprinkled in
        issue(OP_CLEAR, operand_t'($urandom));
        while (tracker.shadow_count < CAPACITY)
        begin
            if ($urandom_range(99) < 92)
            begin
                v = pick_value();
                if (v < 0 && $urandom_range(3) != 0)
                    v = {1'b0, v[OPW-2:0]};
                issue(OP_INSERT, v);
            end
            else
                issue(OP_QUERY, pick_k());
        end

        // full store: dropped inserts, ignored negatives, clamped queries
        issue(OP_INSERT, operand_t'(1));
        issue(OP_INSERT, OPERAND_MIN);
        issue(OP_QUERY, operand_t'(CAPACITY));
        issue(OP_QUERY, OPERAND_MAX);
        for (int i = 0; i < 30; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                issue(OP_INSERT, pick_value());
            else if (r < 90)
                issue(OP_QUERY, pick_k());
            else
                issue(OP_UNUSED, operand_t'($urandom));
        end
        issue(OP_CLEAR, '0);
        issue(OP_QUERY, OPERAND_MAX);
        issue(OP_INSERT, operand_t'($urandom_range(100)));
        issue(OP_QUERY, operand_t'(1));

        // let the pipeline empty, then allow a few cycles for stray results
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
